// ===== rtl/fdf_pkg.sv =====
package fdf_pkg;

   localparam int DELAY_TIME_W  = 20;
   localparam int FRAC_W        = 8;
   localparam int MAX_DELAY_W   = 13;
   localparam int GAIN_W        = 16;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 16;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(26214);
   localparam logic [GAIN_W-1:0] FB_ROUND   = GAIN_W'(16384);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_DELAY     = 1'b0,
      CSR_FEEDBACK_GAIN = 1'b1
   } csr_index_type;

endpackage

// ===== rtl/fdf_ram.sv =====
module fdf_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fractional_delay_flanger_unit.sv =====
// An accepted input goes through S_RD2, S_INTERP and S_FB before rsp_valid
// rises. Inputs are taken only in S_IDLE, after the two sequential reads of
// the single-read-port delay memory, two registered multiplies and the
// write-back. Reset (synchronous, active high) starts a clearing pass that
// zeroes the delay memory, with req_stall high; csr writes still land.
module fractional_delay_flanger_unit #(
   parameter int DELAY_DEPTH  = 4096,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample_in,
   input  logic [fdf_pkg::DELAY_TIME_W-1:0]    req_delay_time,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_sample_out,
   input  logic                                csr_wr_en,
   input  logic [fdf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fdf_pkg::CSR_DATA_W-1:0]      csr_data
);

   import fdf_pkg::*;

   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int LW = AW + 1;
   localparam int PW = LW + FRAC_W;
   localparam int CW = (PW > DELAY_TIME_W) ? PW : DELAY_TIME_W;
   localparam int SW = SAMPLE_WIDTH;
   localparam int IW = SW + FRAC_W + 2;
   localparam int FW = SW + GAIN_W;
   localparam int MW = (LW > MAX_DELAY_W) ? LW : MAX_DELAY_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RD2,
      S_INTERP,
      S_FB,
      S_WR
   } state_type;

   state_type state_ff;

   logic [MW-1:0]           max_delay_ff;
   logic signed [GAIN_W-1:0] gain_ff;
   logic [AW-1:0]           pos_ff;
   logic [AW-1:0]           clr_cnt_ff;
   logic [AW-1:0]           p_ff;
   logic [AW-1:0]           nxt_ff;
   logic [FRAC_W-1:0]       frac_ff;
   logic signed [SW-1:0]    x_ff;
   logic signed [SW-1:0]    d0_ff;
   logic signed [IW-1:0]    interp_ff;
   logic signed [FW-1:0]    fbprod_ff;
   logic                    rsp_valid_ff;
   logic signed [SW-1:0]    rsp_sample_out_ff;

   logic [LW-1:0]           mdt;
   logic [AW-1:0]           p_cur;
   logic [PW-1:0]           span;
   logic [PW-1:0]           vdt;
   logic [PW-1:0]           rp_base;
   logic [PW-1:0]           rp;
   logic [AW-1:0]           rpi;
   logic [LW-1:0]           rpi_p1;
   logic [AW-1:0]           nxt_in;
   logic [LW-1:0]           p_p1;
   logic [AW-1:0]           pos_in;

   logic                    req_accept;
   logic                    out_free;

   logic signed [SW-1:0]    rd_data;
   logic [AW-1:0]           rd_addr;
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   logic [SW-1:0]           mem_wdata;

   logic signed [SW:0]      diff;
   logic signed [IW-1:0]    prod;
   logic signed [IW-1:0]    interp_in;
   logic signed [SW-1:0]    y;
   logic signed [FW-1:0]    fb_round;
   logic signed [SW:0]      fb;
   logic signed [SW+1:0]    sum;
   logic signed [SW-1:0]    sat;

   // delay line length in use and read position
   always_comb begin
      if (max_delay_ff == '0) begin
         mdt = LW'(1);
      end else if (32'(max_delay_ff) > DELAY_DEPTH) begin
         mdt = LW'(DELAY_DEPTH);
      end else begin
         mdt = LW'(max_delay_ff);
      end
   end

   assign p_cur   = ({1'b0, pos_ff} >= mdt) ? '0 : pos_ff;
   assign span    = {mdt, {FRAC_W{1'b0}}};
   assign vdt     = (CW'(req_delay_time) > CW'(span)) ? span : PW'(req_delay_time);
   assign rp_base = {1'b0, p_cur, {FRAC_W{1'b0}}};
   assign rp      = (rp_base >= vdt) ? (rp_base - vdt) : (rp_base + span - vdt);
   assign rpi     = rp[AW+FRAC_W-1:FRAC_W];
   assign rpi_p1  = LW'(rpi) + LW'(1);
   assign nxt_in  = (rpi_p1 >= mdt) ? '0 : rpi_p1[AW-1:0];
   assign p_p1    = LW'(p_cur) + LW'(1);
   assign pos_in  = (p_p1 >= mdt) ? '0 : p_p1[AW-1:0];

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // interpolation and feedback arithmetic
   assign diff      = (SW+1)'(rd_data) - (SW+1)'(d0_ff);
   assign prod      = $signed({1'b0, frac_ff}) * diff;
   assign interp_in = {{2{d0_ff[SW-1]}}, d0_ff, {FRAC_W{1'b0}}} + prod;
   assign y         = interp_ff[SW+FRAC_W-1:FRAC_W];
   assign fb_round  = fbprod_ff + FW'($signed({1'b0, FB_ROUND}));
   assign fb        = fb_round[FW-1:GAIN_W-1];
   assign sum       = (SW+2)'(x_ff) + (SW+2)'(fb);

   always_comb begin
      if (sum[SW+1:SW-1] == 3'b000 || sum[SW+1:SW-1] == 3'b111) begin
         sat = sum[SW-1:0];
      end else begin
         sat = {sum[SW+1], {(SW-1){~sum[SW+1]}}};
      end
   end

   assign rd_addr   = (state_ff == S_IDLE) ? rpi : nxt_ff;
   assign mem_we    = (state_ff == S_CLEAR) || (state_ff == S_WR);
   assign mem_waddr = (state_ff == S_CLEAR) ? clr_cnt_ff : p_ff;
   assign mem_wdata = (state_ff == S_CLEAR) ? '0 : sat;

   fdf_ram #(
      .DEPTH (DELAY_DEPTH),
      .WIDTH (SW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_delay_ff <= MW'(DELAY_DEPTH);
         gain_ff      <= GAIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_DELAY: begin
               max_delay_ff <= MW'(csr_data[MAX_DELAY_W-1:0]);
            end
            CSR_FEEDBACK_GAIN: begin
               gain_ff <= csr_data[GAIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_FB) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + AW'(1);
               if (clr_cnt_ff == AW'(DELAY_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_accept) begin
                  x_ff     <= req_sample_in;
                  p_ff     <= p_cur;
                  nxt_ff   <= nxt_in;
                  frac_ff  <= rp[FRAC_W-1:0];
                  pos_ff   <= pos_in;
                  state_ff <= S_RD2;
               end
            end
            S_RD2: begin
               d0_ff    <= rd_data;
               state_ff <= S_INTERP;
            end
            S_INTERP: begin
               interp_ff <= interp_in;
               state_ff  <= S_FB;
            end
            S_FB: begin
               // hold until the output register frees up
               if (out_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_sample_out_ff <= y;
                  fbprod_ff         <= y * gain_ff;
                  state_ff          <= S_WR;
               end
            end
            S_WR: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

   a_rsp_from_fb: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FB)
      else $error("result raised outside the feedback step");

   a_accept_starts_read: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == S_RD2)
      else $error("transfer did not start the second read");

   a_no_result_drop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FB && rsp_valid_ff && rsp_stall) |=>
      (state_ff == S_FB && rsp_valid_ff))
      else $error("pending result overwritten");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff == S_WR) |-> {1'b0, p_ff} < mdt)
      else $error("write-back beyond active line length");

   a_next_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD2 |-> {1'b0, nxt_ff} < mdt)
      else $error("second read beyond active line length");

endmodule
